### rtl/lru_pkg.sv
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package lru_pkg;

  // Page fields on the ports are fixed at 16 bits.
  localparam int PageW = 16;
  // Frame index and rank fields are sized for the largest frame count (16).
  localparam int IdxW = 4;
  localparam int SlotW = 2;
  localparam logic [PageW-1:0] FaultMax = '1;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic             vld;
    logic             last;
    logic [PageW-1:0] page;
    logic             hit;
    logic [IdxW-1:0]  hit_idx;
    logic [IdxW-1:0]  hit_rank;
    logic             empty;
    logic [IdxW-1:0]  empty_idx;
    logic [IdxW-1:0]  max_rank;
    logic [IdxW-1:0]  max_idx;
    logic [PageW-1:0] max_page;
  } lru_tok_t;

  // Update broadcast from the decision logic to every cell.
  typedef struct packed {
    logic             commit;
    logic             clear;
    logic             fill;
    logic             age_all;
    logic [IdxW-1:0]  slot;
    logic [IdxW-1:0]  limit;
    logic [PageW-1:0] page;
  } lru_upd_t;

endpackage
`default_nettype wire

### rtl/lru_ref_if.sv
// Page reference channel: valid/ready plus the reference fields.
`timescale 1ns / 1ps
`default_nettype none
interface lru_ref_if;
  logic                     valid;
  logic                     ready;
  logic [lru_pkg::PageW-1:0] page_number;
  logic                     last_of_run;

  modport source(output valid, output page_number, output last_of_run, input ready);
  modport sink(input valid, input page_number, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/lru_res_if.sv
// Result channel: valid/ready plus the result fields.
`timescale 1ns / 1ps
`default_nettype none
interface lru_res_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [lru_pkg::SlotW-1:0] frame_slot;
  logic                     evicted_valid;
  logic [lru_pkg::PageW-1:0] evicted_page;
  logic [lru_pkg::PageW-1:0] fault_count;

  modport source(output valid, output hit, output frame_slot, output evicted_valid,
                 output evicted_page, output fault_count, input ready);
  modport sink(input valid, input hit, input frame_slot, input evicted_valid,
               input evicted_page, input fault_count, output ready);
endinterface
`default_nettype wire

### rtl/lru_cell.sv
// One frame cell: holds page, valid and rank, folds itself into the search token.
`timescale 1ns / 1ps
`default_nettype none
module lru_cell #(
  parameter int FRAME_COUNT = 4,
  parameter int Index = 0
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               advance,
  input  lru_pkg::lru_tok_t tok_in,
  input  lru_pkg::lru_upd_t upd,
  output lru_pkg::lru_tok_t tok_out
);
  import lru_pkg::*;

  localparam int RankW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Index);

  logic [PageW-1:0] page;
  logic             valid;
  logic [RankW-1:0] rank;
  logic [IdxW-1:0]  rank_ext;
  lru_tok_t         tok_next;

  assign rank_ext = IdxW'(rank);

  always_comb begin
    tok_next = tok_in;
    if (!tok_in.hit && valid && page == tok_in.page) begin
      tok_next.hit      = 1'b1;
      tok_next.hit_idx  = MyIdx;
      tok_next.hit_rank = rank_ext;
    end
    if (!tok_in.empty && !valid) begin
      tok_next.empty     = 1'b1;
      tok_next.empty_idx = MyIdx;
    end
    // first cell seeds the victim search; later cells win only when strictly older
    if (Index == 0 || rank_ext > tok_in.max_rank) begin
      tok_next.max_rank = rank_ext;
      tok_next.max_idx  = MyIdx;
      tok_next.max_page = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else if (advance) begin
      tok_out.vld <= tok_next.vld;
    end
    if (advance) begin
      tok_out.last      <= tok_next.last;
      tok_out.page      <= tok_next.page;
      tok_out.hit       <= tok_next.hit;
      tok_out.hit_idx   <= tok_next.hit_idx;
      tok_out.hit_rank  <= tok_next.hit_rank;
      tok_out.empty     <= tok_next.empty;
      tok_out.empty_idx <= tok_next.empty_idx;
      tok_out.max_rank  <= tok_next.max_rank;
      tok_out.max_idx   <= tok_next.max_idx;
      tok_out.max_page  <= tok_next.max_page;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.commit) begin
      if (upd.clear) begin
        valid <= 1'b0;
        rank  <= '0;
      end else if (upd.slot == MyIdx) begin
        rank <= '0;
        if (upd.fill) begin
          valid <= 1'b1;
        end
      end else if (valid && (upd.age_all || rank_ext < upd.limit)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.commit && !upd.clear && upd.fill && upd.slot == MyIdx) begin
      page <= upd.page;
    end
  end

endmodule
`default_nettype wire

### rtl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: cell chain, decision and result register.
//
//   channel | dir | payload                                                   | handshake
//   --------+-----+-----------------------------------------------------------+----------
//   req     | in  | page_number[15:0], last_of_run                            | valid/ready
//   rsp     | out | hit, frame_slot[1:0], evicted_valid, evicted_page[15:0],  | valid/ready
//           |     | fault_count[15:0]                                         |
//
// Flow: a reference walks the chain of FRAME_COUNT cells, one cell per cycle,
// collecting hit, first empty frame and the oldest frame. Its result is
// registered at the edge that empties the chain, so req.ready is high again in
// the next cycle and the next reference can enter.
// Reset (rst, synchronous): all frames empty, ranks and fault count zero.
// Stalls: a result waiting on rsp does not block acceptance; a later item
// holds at the end of the chain until the result register frees.
`timescale 1ns / 1ps
`default_nettype none
module lru_page_replacement_top #(
  parameter int FRAME_COUNT = 4,
  parameter int PAGE_BITS = 16
) (
  input wire        clk,
  input wire        rst,
  lru_ref_if.sink   req,
  lru_res_if.source rsp
);
  import lru_pkg::*;

  // only the low PAGE_BITS bits of a page take part
  localparam int KeepW = (PAGE_BITS < PageW) ? PAGE_BITS : PageW;

  lru_tok_t         tok [FRAME_COUNT+1];
  lru_tok_t         tok_head;
  lru_tok_t         tl;
  lru_upd_t         upd;
  logic [FRAME_COUNT:0] tok_vld;
  logic             busy;
  logic             advance;
  logic             commit;
  logic [PageW-1:0] fault_total;
  logic [PageW-1:0] fault_next;
  logic [IdxW-1:0]  slot;
  logic             ev_valid;

  // token entering the first cell
  always_comb begin
    tok_head         = '0;
    tok_head.vld     = req.valid && req.ready;
    tok_head.last    = req.last_of_run;
    tok_head.page    = PageW'(req.page_number[KeepW-1:0]);
  end

  assign tok[0] = tok_head;

  genvar g;
  generate
    for (g = 0; g < FRAME_COUNT; g++) begin : g_cell
      lru_cell #(
        .FRAME_COUNT(FRAME_COUNT),
        .Index(g)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .advance(advance),
        .tok_in(tok[g]),
        .upd(upd),
        .tok_out(tok[g+1])
      );
    end
    for (g = 0; g <= FRAME_COUNT; g++) begin : g_vld
      assign tok_vld[g] = tok[g].vld;
    end
  endgenerate

  // one reference in flight at a time; next one enters once the chain drains
  assign busy      = |tok_vld[FRAME_COUNT:1];
  assign req.ready = !busy;

  assign tl      = tok[FRAME_COUNT];
  assign advance = !(tl.vld && rsp.valid && !rsp.ready);
  assign commit  = tl.vld && advance;

  // decision at the end of the chain
  always_comb begin
    if (tl.hit) begin
      slot = tl.hit_idx;
    end else if (tl.empty) begin
      slot = tl.empty_idx;
    end else begin
      slot = tl.max_idx;
    end
    ev_valid   = !tl.hit && !tl.empty;
    fault_next = fault_total;
    if (!tl.hit && fault_total != FaultMax) begin
      fault_next = fault_total + 1'b1;
    end
  end

  // a hit ages frames younger than the hit one; a fill ages every valid frame
  always_comb begin
    upd         = '0;
    upd.commit  = commit;
    upd.clear   = tl.last;
    upd.fill    = !tl.hit;
    upd.age_all = !tl.hit;
    upd.slot    = slot;
    upd.limit   = tl.hit_rank;
    upd.page    = tl.page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_total <= '0;
    end else if (commit) begin
      fault_total <= tl.last ? '0 : fault_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.hit           <= tl.hit;
      rsp.frame_slot    <= slot[SlotW-1:0];
      rsp.evicted_valid <= ev_valid;
      rsp.evicted_page  <= ev_valid ? tl.max_page : '0;
      rsp.fault_count   <= fault_next;
    end
  end

endmodule
`default_nettype wire

### rtl/lru_chk.sv
// Port-level checks for the LRU page replacement block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lru_chk (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        hit,
  input wire        evicted_valid,
  input wire [15:0] evicted_page,
  input wire [15:0] fault_count
);

  // a hit never replaces a page
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted_valid)
    else $error("hit reported with an eviction");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == 16'd0)
    else $error("evicted page not zero without eviction");

  // a fault is always counted
  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> fault_count != 16'd0)
    else $error("fault with zero fault count");

  // one reference in the chain at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in the chain");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(fault_count))
    else $error("result changed while stalled");

endmodule

bind lru_page_replacement_top lru_chk u_lru_chk (
  .clk(clk),
  .rst(rst),
  .in_valid(req.valid),
  .in_ready(req.ready),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .hit(rsp.hit),
  .evicted_valid(rsp.evicted_valid),
  .evicted_page(rsp.evicted_page),
  .fault_count(rsp.fault_count)
);
`default_nettype wire

### tb/testbench.sv
// Testbench for lru_page_replacement_top: drives page references and checks every result.
`timescale 1ns / 1ps
module testbench;
  import lru_pkg::*;

  // Block configuration under test and run sizing.
  localparam int FRAMES = 4;
  localparam int ITEM_CYCLES = FRAMES + 1;   // chain walk + result register
  localparam int HOLD_CYCLES = 300;          // long receiver hold-off
  localparam int IDLE_LIMIT = 3000;          // cycles with no item moving on either channel
  localparam int RANDOM_ITEMS = 1500;
  localparam int MISS_ITEMS = 200;           // all-miss stream through full frames

  // One expected result per accepted reference.
  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] frame_slot;
    logic             evicted_valid;
    logic [PageW-1:0] evicted_page;
    logic [PageW-1:0] fault_count;
  } lru_result_t;

  logic clk = 1'b0;
  logic rst;

  lru_ref_if req_ch();
  lru_res_if rsp_ch();

  lru_page_replacement_top #(
    .FRAME_COUNT(FRAMES),
    .PAGE_BITS(PageW)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Page table predictor: its own copy of frames, recency and fault count.
  // Age 0 is the most recently used frame; valid frames hold ages 0..used-1.
  // ---------------------------------------------------------------------------
  logic [PageW-1:0] frame_page [FRAMES];
  logic             frame_used [FRAMES];
  int unsigned      frame_age [FRAMES];
  logic [PageW-1:0] fault_total;

  lru_result_t pending_results[$];
  int unsigned error_count = 0;

  // End of a run: frames empty, recency and fault count cleared.
  function automatic void clear_frames();
    for (int i = 0; i < FRAMES; i++) begin
      frame_used[i] = 1'b0;
      frame_age[i] = 0;
    end
    fault_total = '0;
  endfunction

  // Age every used frame younger than limit, then make slot the newest.
  // A hit passes its own age (only younger frames move); a fill ages all.
  function automatic void refresh_frame(int slot, int unsigned limit);
    for (int i = 0; i < FRAMES; i++) begin
      if (i != slot && frame_used[i] && frame_age[i] < limit) frame_age[i]++;
    end
    frame_age[slot] = 0;
  endfunction

  function automatic lru_result_t resolve_reference(logic [PageW-1:0] page, logic last_ref);
    lru_result_t res;
    int slot;
    res = '0;
    slot = -1;
    // Lowest matching frame wins.
    for (int i = 0; i < FRAMES; i++) begin
      if (slot < 0 && frame_used[i] && frame_page[i] == page) slot = i;
    end
    if (slot >= 0) begin
      res.hit = 1'b1;
      refresh_frame(slot, frame_age[slot]);
    end else begin
      if (fault_total != FaultMax) fault_total++;   // saturating count
      // Lowest empty frame first.
      for (int i = 0; i < FRAMES; i++) begin
        if (slot < 0 && !frame_used[i]) slot = i;
      end
      // All full: oldest frame, lowest index on a tie.
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < FRAMES; i++) begin
          if (frame_age[i] > frame_age[slot]) slot = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page = frame_page[slot];
      end
      frame_page[slot] = page;
      frame_used[slot] = 1'b1;
      refresh_frame(slot, 32'hFFFF_FFFF);
    end
    res.frame_slot = SlotW'(slot);
    res.fault_count = fault_total;
    if (last_ref) clear_frames();
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker.
  // ---------------------------------------------------------------------------
  int unsigned stall_pct = 0;    // chance of starting a stall run, percent
  int unsigned stall_left = 0;
  int unsigned hold_token = 0;   // bumped by a test to ask for a long hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Receiver: short random stall runs, plus a long hold on request.
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(5);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [PageW-1:0] want,
                                      logic [PageW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    lru_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no reference outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit", PageW'(want.hit), PageW'(rsp_ch.hit));
        check_field("frame_slot", PageW'(want.frame_slot), PageW'(rsp_ch.frame_slot));
        check_field("evicted_valid", PageW'(want.evicted_valid),
                    PageW'(rsp_ch.evicted_valid));
        check_field("evicted_page", want.evicted_page, rsp_ch.evicted_page);
        check_field("fault_count", want.fault_count, rsp_ch.fault_count);
      end
    end
  end

  // Watchdog: too long with no item moving on either channel.
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Reference side. Tasks are entered and left at a falling edge; valid stays
  // high after an item so back-to-back items need no extra assignment.
  // ---------------------------------------------------------------------------
  task automatic send_ref(input logic [PageW-1:0] page, input logic last_ref);
    req_ch.valid <= 1'b1;
    req_ch.page_number <= page;
    req_ch.last_of_run <= last_ref;
    do @(posedge clk); while (!req_ch.ready);
    pending_results.push_back(resolve_reference(page, last_ref));
    @(negedge clk);
  endtask

  task automatic pause_refs(input int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Sender idles until every outstanding result has been checked.
  task automatic wait_results_done();
    pause_refs(1);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Page extremes, fills, hits at each age, evictions and run ends on
  // both a hit and a miss.
  task automatic test_directed();
    stall_pct = 0;
    send_ref(16'h0000, 1'b0);   // empty table: frame 0
    send_ref(16'hFFFF, 1'b0);   // all-ones page: frame 1
    send_ref(16'h0000, 1'b0);   // hit on the older of two
    send_ref(16'h8000, 1'b0);
    send_ref(16'h0001, 1'b0);   // table now full
    send_ref(16'h1234, 1'b0);   // evicts the least recent page
    send_ref(16'h8000, 1'b0);   // hit on a middle age
    send_ref(16'hFFFF, 1'b0);   // miss, evicts again
    send_ref(16'h0001, 1'b0);
    send_ref(16'h0001, 1'b0);   // hit on the newest frame
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b1);   // miss that ends the run
    send_ref(16'hAAAA, 1'b0);   // fresh run: same page misses again
    send_ref(16'hAAAA, 1'b1);   // hit that ends the run
    send_ref(16'h0000, 1'b1);   // single-reference run
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h7FFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    wait_results_done();
  endtask

  // Receiver holds off for a long stretch while references keep coming, so
  // the block fills and stalls its input; then the sender drains.
  task automatic test_backpressure();
    stall_pct = 0;
    hold_token++;
    for (int n = 0; n < 40; n++) send_ref(16'h0100 + PageW'($urandom_range(5)), 1'b0);
    wait_results_done();
  endtask

  // Bursty stream drawn mostly from a small working set so hits, fills and
  // evictions all occur; some full-range pages and occasional run ends.
  task automatic test_random();
    logic [PageW-1:0] working_set [8];
    int unsigned set_size;
    int unsigned burst_left;
    logic [PageW-1:0] page;
    logic last_ref;
    logic new_set;
    set_size = 4;
    burst_left = 0;
    new_set = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Stall level steps through none, light, medium and heavy.
      if (n % 250 == 0) begin
        case ((n / 250) % 4)
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      if (new_set) begin
        set_size = $urandom_range(2, 8);
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(7))
            0: working_set[i] = '0;
            1: working_set[i] = '1;
            default: working_set[i] = PageW'($urandom);
          endcase
        end
        new_set = 1'b0;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(9) < 7) pause_refs($urandom_range(1, 10));
      end
      burst_left--;
      if ($urandom_range(19) == 0) page = PageW'($urandom);
      else page = working_set[$urandom_range(set_size - 1)];
      last_ref = ($urandom_range(39) == 0);
      send_ref(page, last_ref);
      if (last_ref || $urandom_range(99) == 0) new_set = 1'b1;
    end
    wait_results_done();
  endtask

  // Five pages cycled through four frames always miss, so once the frames are full every item
  // evicts and the fault count climbs each time; a run end then restarts it from zero.
  task automatic test_miss_stream();
    stall_pct = 0;
    for (int n = 0; n < MISS_ITEMS; n++) send_ref(16'h4000 + PageW'(n % 5), 1'b0);
    send_ref(16'hFFFF, 1'b1);
    send_ref(16'h4000, 1'b0);
    send_ref(16'h4000, 1'b0);
    wait_results_done();
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.page_number = '0;
    req_ch.last_of_run = 1'b0;
    rsp_ch.ready = 1'b0;
    clear_frames();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random();
    test_miss_stream();

    // Let any stray result surface before the verdict.
    repeat (4 * ITEM_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
